/* rtl/mspd_pkg.sv */
// Shared types and constants of the motor speed PID drive.
// Used by the step datapath and by the top level; depends on nothing.
package mspd_pkg;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] REQ_SPEED = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_POS   = 2'd2;

  // Drive command codes.
  localparam logic [1:0] DRIVE_STOP = 2'd0;
  localparam logic [1:0] DRIVE_FWD  = 2'd1;
  localparam logic [1:0] DRIVE_BWD  = 2'd2;
  localparam logic [1:0] DRIVE_HOLD = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_KP       = 3'd1;
  localparam logic [2:0] REG_KI       = 3'd2;
  localparam logic [2:0] REG_KD       = 3'd3;
  localparam logic [2:0] REG_KCOUNT   = 3'd4;
  localparam logic [2:0] REG_LIMIT    = 3'd5;

  // Register reset values.
  localparam logic signed [23:0] SETPOINT_RST = 24'sd1966080;
  localparam logic [31:0]        KP_RST       = 32'd0;
  localparam logic [31:0]        KI_RST       = 32'd214748;
  localparam logic [31:0]        KD_RST       = 32'd64425;
  localparam logic [23:0]        KCOUNT_RST   = 24'd1525201;
  localparam logic signed [31:0] LIMIT_RST    = 32'sd1100;

  // Plus and minus one in Q1.30 for the integral and control clamps.
  localparam logic signed [47:0] ONE_Q30     = 48'sd1073741824;
  localparam logic signed [47:0] NEG_ONE_Q30 = -48'sd1073741824;

  typedef struct packed {
    logic signed [23:0] setpoint;
    logic [31:0]        kp;
    logic [31:0]        ki;
    logic [31:0]        kd;
    logic [23:0]        kcount;
    logic signed [31:0] limit;
  } mspd_cfg_t;

  typedef struct packed {
    logic signed [15:0] last_count;
    logic signed [29:0] duty_now;
    logic signed [29:0] duty_before;
    logic signed [31:0] integral;
    logic signed [31:0] control;
    logic               stop_latched;
  } mspd_state_t;

endpackage

/* rtl/mspd_step.sv */
// Next-state datapath of the motor speed PID drive: speed scaling, PID step
// and stop-limit check for one request. Depends on mspd_pkg.
module mspd_step (
  input  mspd_pkg::mspd_cfg_t   cfg,
  input  mspd_pkg::mspd_state_t st,
  input  logic [1:0]            req_type,
  input  logic signed [15:0]    counter_value,
  input  logic signed [31:0]    position,
  output mspd_pkg::mspd_state_t st_nxt
);
  import mspd_pkg::*;

  localparam logic signed [33:0] DUTY_MAX = 34'sd536870911;
  localparam logic signed [33:0] DUTY_MIN = -34'sd536870912;

  // Speed sample path.
  logic signed [16:0] diff;
  logic signed [24:0] kcount_s;
  logic signed [41:0] spd_prod;
  logic signed [33:0] spd_scaled;
  logic signed [29:0] duty_sat;

  assign diff = $signed({counter_value[15], counter_value})
              - $signed({st.last_count[15], st.last_count});
  assign kcount_s = $signed({1'b0, cfg.kcount});
  assign spd_prod = diff * kcount_s;
  // Arithmetic shift of the signed product is the floor division by 2^8.
  assign spd_scaled = $signed(spd_prod[41:8]);

  always_comb begin
    if (spd_scaled > DUTY_MAX) begin
      duty_sat = DUTY_MAX[29:0];
    end else if (spd_scaled < DUTY_MIN) begin
      duty_sat = DUTY_MIN[29:0];
    end else begin
      duty_sat = spd_scaled[29:0];
    end
  end

  // Control tick path: three gains work in parallel on the error terms.
  logic signed [30:0] err;
  logic signed [30:0] chg;
  logic signed [32:0] kp_s;
  logic signed [32:0] ki_s;
  logic signed [32:0] kd_s;
  logic signed [63:0] p_prod;
  logic signed [63:0] i_prod;
  logic signed [63:0] d_prod;
  logic signed [45:0] p_q;
  logic signed [45:0] i_q;
  logic signed [45:0] d_q;
  logic signed [47:0] int_sum;
  logic signed [31:0] int_new;
  logic signed [47:0] ctl_sum;
  logic signed [31:0] ctl_new;

  assign err = $signed({{7{cfg.setpoint[23]}}, cfg.setpoint})
             - $signed({st.duty_now[29], st.duty_now});
  assign chg = $signed({st.duty_now[29], st.duty_now})
             - $signed({st.duty_before[29], st.duty_before});
  assign kp_s = $signed({1'b0, cfg.kp});
  assign ki_s = $signed({1'b0, cfg.ki});
  assign kd_s = $signed({1'b0, cfg.kd});
  assign p_prod = err * kp_s;
  assign i_prod = err * ki_s;
  assign d_prod = chg * kd_s;
  assign p_q = $signed(p_prod[63:18]);
  assign i_q = $signed(i_prod[63:18]);
  assign d_q = $signed(d_prod[63:18]);

  assign int_sum = $signed({{16{st.integral[31]}}, st.integral})
                 + $signed({{2{i_q[45]}}, i_q});

  always_comb begin
    if (int_sum > ONE_Q30) begin
      int_new = ONE_Q30[31:0];
    end else if (int_sum < NEG_ONE_Q30) begin
      int_new = NEG_ONE_Q30[31:0];
    end else begin
      int_new = int_sum[31:0];
    end
  end

  // The control clamp uses the freshly clamped integral but never feeds back.
  assign ctl_sum = $signed({{2{p_q[45]}}, p_q})
                 + $signed({{16{int_new[31]}}, int_new})
                 - $signed({{2{d_q[45]}}, d_q});

  always_comb begin
    if (ctl_sum > ONE_Q30) begin
      ctl_new = ONE_Q30[31:0];
    end else if (ctl_sum < NEG_ONE_Q30) begin
      ctl_new = NEG_ONE_Q30[31:0];
    end else begin
      ctl_new = ctl_sum[31:0];
    end
  end

  // Position report path; a zero limit never trips.
  logic limit_hit;

  assign limit_hit = ((cfg.limit > 32'sd0) && (position >= cfg.limit))
                  || ((cfg.limit < 32'sd0) && (position <= cfg.limit));

  always_comb begin
    st_nxt = st;
    case (req_type)
      REQ_SPEED: begin
        st_nxt.last_count  = counter_value;
        st_nxt.duty_before = st.duty_now;
        st_nxt.duty_now    = duty_sat;
      end
      REQ_TICK: begin
        st_nxt.integral = int_new;
        st_nxt.control  = ctl_new;
      end
      REQ_POS: begin
        st_nxt.stop_latched = st.stop_latched | limit_hit;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

/* rtl/motor_speed_pid_drive.sv */
// Top level of the motor speed PID drive: stream ports, APB register file,
// state registers and the result stage. Depends on mspd_pkg and mspd_step.
//
// The block accepts one word per clock cycle while the output is not held
// back and returns exactly one result word per input word, in order. The
// state update of a word happens at the edge that accepts it, through a
// single pass of the step datapath (one 17x25 multiplier for speed samples,
// three parallel 31x33 multipliers for control ticks); the result word is
// formed from the updated state and registered once the output register is
// free. The pending stage keeps the input accepting while one result waits.
// Request kind 3 changes nothing but still returns a result.
module motor_speed_pid_drive (
  input  logic        clk,
  input  logic        rst_n,
  // Input word: tdata [15:0] counter_value, [47:16] position.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // Input tuser: [1:0] req_type.
  input  logic [1:0]  in_tuser,
  // Result word: tdata [1:0] drive, [8:2] duty_percent,
  // [38:9] measured_duty, [39] stopped.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mspd_pkg::*;

  mspd_cfg_t   cfg_r;
  mspd_state_t state_r;
  mspd_state_t state_nxt;
  logic        pend_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [39:0] out_data_nxt;
  logic        in_accept;
  logic        out_free;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // Register file.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= SETPOINT_RST;
      cfg_r.kp       <= KP_RST;
      cfg_r.ki       <= KI_RST;
      cfg_r.kd       <= KD_RST;
      cfg_r.kcount   <= KCOUNT_RST;
      cfg_r.limit    <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SETPOINT: cfg_r.setpoint <= $signed(cfg_pwdata[23:0]);
        REG_KP:       cfg_r.kp       <= cfg_pwdata;
        REG_KI:       cfg_r.ki       <= cfg_pwdata;
        REG_KD:       cfg_r.kd       <= cfg_pwdata;
        REG_KCOUNT:   cfg_r.kcount   <= cfg_pwdata[23:0];
        REG_LIMIT:    cfg_r.limit    <= $signed(cfg_pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SETPOINT: cfg_prdata = {{8{cfg_r.setpoint[23]}}, cfg_r.setpoint};
      REG_KP:       cfg_prdata = cfg_r.kp;
      REG_KI:       cfg_prdata = cfg_r.ki;
      REG_KD:       cfg_prdata = cfg_r.kd;
      REG_KCOUNT:   cfg_prdata = {8'd0, cfg_r.kcount};
      REG_LIMIT:    cfg_prdata = cfg_r.limit;
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Step datapath.
  mspd_step u_step (
    .cfg           (cfg_r),
    .st            (state_r),
    .req_type      (in_tuser),
    .counter_value ($signed(in_tdata[15:0])),
    .position      ($signed(in_tdata[47:16])),
    .st_nxt        (state_nxt)
  );

  // Handshake: a word is pending between its state update and its result.
  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = ~pend_r | out_free;
  assign in_accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        pend_r <= 1'b1;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= pend_r;
      end
    end
  end

  // Result formatting from the state left by the pending word.
  logic [1:0]  drive;
  logic [6:0]  duty_pct;
  logic [23:0] sp_mag;
  logic [7:0]  sp_int;
  logic [30:0] ctl_mag;
  logic [37:0] ctl_pct;
  logic [31:0] ctl_neg;

  assign sp_mag  = cfg_r.setpoint[23] ? 24'd0 - cfg_r.setpoint : cfg_r.setpoint;
  assign sp_int  = sp_mag[23:16];
  assign ctl_neg = 32'd0 - state_r.control;
  assign ctl_mag = state_r.control[31] ? ctl_neg[30:0] : state_r.control[30:0];
  // The control magnitude never exceeds 2^30, so ctl_pct[36:30] is at most 100.
  assign ctl_pct = ctl_mag * 7'd100;

  always_comb begin
    if (state_r.stop_latched) begin
      drive    = DRIVE_STOP;
      duty_pct = 7'd0;
    end else if (state_r.control == 32'sd0) begin
      if (cfg_r.setpoint > 24'sd0) begin
        drive = DRIVE_FWD;
      end else if (cfg_r.setpoint < 24'sd0) begin
        drive = DRIVE_BWD;
      end else begin
        drive = DRIVE_HOLD;
      end
      duty_pct = (sp_int > 8'd100) ? 7'd100 : sp_int[6:0];
    end else begin
      drive    = state_r.control[31] ? DRIVE_BWD : DRIVE_FWD;
      duty_pct = ctl_pct[36:30];
    end
  end

  assign out_data_nxt = {state_r.stop_latched, state_r.duty_now, duty_pct, drive};

  always_ff @(posedge clk) begin
    if (out_free && pend_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stop_latched |=> state_r.stop_latched)
    else $error("stop latch cleared outside reset");

  a_integral_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.integral <= 32'sd1073741824) && (state_r.integral >= -32'sd1073741824))
    else $error("integral left its clamp range");

  a_control_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.control <= 32'sd1073741824) && (state_r.control >= -32'sd1073741824))
    else $error("control value left its clamp range");

  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[39]) |-> (out_data_r[1:0] == DRIVE_STOP)
      && (out_data_r[8:2] == 7'd0))
    else $error("stopped result drives the motor");

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[8:2] <= 7'd100))
    else $error("duty percent above 100");
`endif

endmodule
